@@ rtl/value_noise_2d_macros.svh @@
// Assertion macros for the value_noise_2d block.
// Used by the top level; expects clk and rst_n in the including scope.
`ifndef VALUE_NOISE_2D_MACROS_SVH
`define VALUE_NOISE_2D_MACROS_SVH

// same-cycle implication
`define VN2_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define VN2_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/vn2_pkg.sv @@
// Shared types and constants for the value_noise_2d block.
// No dependencies.
`default_nettype none

package vn2_pkg;

  typedef logic [63:0]        word64_t;
  typedef logic signed [23:0] corner_t;

  localparam int FRAC_BITS_DEF = 16;
  localparam int NSTG          = 15;
  localparam int IN_W          = 128;
  localparam int NOISE_W       = 18;
  localparam int OUT_W         = 24;

  localparam word64_t KX_MUL  = 64'h9e3779b97f4a7c15;
  localparam word64_t KZ_MUL  = 64'hc2b2ae3d27d4eb4f;
  localparam word64_t KXZ_MUL = KX_MUL + KZ_MUL;
  localparam word64_t MIX_C1  = 64'hbf58476d1ce4e5b9;
  localparam word64_t MIX_C2  = 64'h94d049bb133111eb;

endpackage

`default_nettype wire

@@ rtl/value_noise_2d.sv @@
// Top level of the 2D value noise sampler: 15-stage pipeline.
// Depends on vn2_pkg, vn2_mul64, vn2_weight, vn2_mix and value_noise_2d_macros.svh.
//
//   Channel  Direction  Payload
//   in_      slave      tdata[127:0] = x_coord, z_coord, seed
//   out_     master     tdata[23:0]  = noise_value (18 bits), zero padded
//
// One word enters per cycle unless every stage is full and out_tready is low.
// The splitmix finalizer holds two 64-bit low-half multiplies,
// each split into partial products and a sum stage.
// Reset clears the stage valid bits only.
// A stage holds while the stage after it is full and stalled; empty stages fill in.
`default_nettype none

module value_noise_2d #(
  parameter int FRAC_BITS = vn2_pkg::FRAC_BITS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_tvalid,
  output logic                          in_tready,
  input  wire logic [vn2_pkg::IN_W-1:0] in_tdata,   // x_coord, z_coord, seed
  output logic                          out_tvalid,
  input  wire logic                     out_tready,
  output logic [vn2_pkg::OUT_W-1:0]     out_tdata   // noise_value
);
  import vn2_pkg::*;
  `include "value_noise_2d_macros.svh"

  localparam int F  = FRAC_BITS;
  localparam int CW = 32 - F;
  localparam int PW = F + 27;
  localparam logic signed [PW-1:0] LHALF = PW'(1) << (F-1);
  localparam logic [F:0]           W_ONE = (F+1)'(1) << F;

  logic [NSTG:1] v_r;
  logic [NSTG:1] v_in;
  logic [NSTG:1] en;

  // stage 1
  logic signed [CW-1:0] cx1_r, cz1_r;
  logic [F-1:0]         fx1_r, fz1_r;
  word64_t              seed1_r, seed2_r, seed3_r;
  // stages 2..5
  word64_t              px, pz;
  word64_t              ksum4_r;
  word64_t              key5_r [4];
  logic [F:0]           u_w, v_w;
  // stages 6..10
  logic [F:0]           u_d_r [6:10];
  logic [F:0]           v_d_r [6:12];
  corner_t              corner_w [4];
  // stages 11..15
  logic signed [24:0]   d0, d1, d2;
  logic signed [PW-1:0] lp0_r, lp1_r, lp2_r;
  corner_t              n00_r, n01_r;
  corner_t              nx0_r, nx1_r, nx0d_r;
  corner_t              r_r;
  logic signed [NOISE_W-1:0] o_r;

  // valid chain and per-stage advance
  assign v_in = {v_r[NSTG-1:1], in_tvalid};

  always_comb begin
    en[NSTG] = !v_r[NSTG] || out_tready;
    for (int k = NSTG - 1; k >= 1; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int k = 1; k <= NSTG; k++) begin
        if (en[k]) v_r[k] <= v_in[k];
      end
    end
  end

  assign in_tready  = en[1];
  assign out_tvalid = v_r[NSTG];
  assign out_tdata  = {(OUT_W-NOISE_W)'(0), o_r};

  // stage 1: split into cell and fraction
  always_ff @(posedge clk) begin
    if (en[1]) begin
      cx1_r   <= in_tdata[31:F];
      fx1_r   <= in_tdata[F-1:0];
      cz1_r   <= in_tdata[63:32+F];
      fz1_r   <= in_tdata[32+F-1:32];
      seed1_r <= in_tdata[127:64];
    end
    if (en[2]) seed2_r <= seed1_r;
    if (en[3]) seed3_r <= seed2_r;
  end

  // stages 2..3: cell scaling
  vn2_mul64 u_mulx (
    .clk (clk),
    .en  (en[3:2]),
    .a   (64'(cx1_r)),
    .b   (KX_MUL),
    .p   (px)
  );

  vn2_mul64 u_mulz (
    .clk (clk),
    .en  (en[3:2]),
    .a   (64'(cz1_r)),
    .b   (KZ_MUL),
    .p   (pz)
  );

  // stages 2..5: weights
  vn2_weight #(.FRAC_BITS(F)) u_wx (
    .clk  (clk),
    .en   (en[5:2]),
    .frac (fx1_r),
    .w    (u_w)
  );

  vn2_weight #(.FRAC_BITS(F)) u_wz (
    .clk  (clk),
    .en   (en[5:2]),
    .frac (fz1_r),
    .w    (v_w)
  );

  // stages 4..5: corner keys
  always_ff @(posedge clk) begin
    if (en[4]) ksum4_r <= seed3_r + px + pz;
    if (en[5]) begin
      key5_r[0] <= ksum4_r;
      key5_r[1] <= ksum4_r + KX_MUL;
      key5_r[2] <= ksum4_r + KZ_MUL;
      key5_r[3] <= ksum4_r + KXZ_MUL;
    end
  end

  // stages 6..10: hash each corner
  for (genvar g = 0; g < 4; g++) begin : g_corner
    vn2_mix u_mix (
      .clk    (clk),
      .en     (en[10:6]),
      .key    (key5_r[g]),
      .corner (corner_w[g])
    );
  end

  // hold weights alongside the hash
  always_ff @(posedge clk) begin
    if (en[6]) begin
      u_d_r[6] <= u_w;
      v_d_r[6] <= v_w;
    end
    for (int k = 7; k <= 10; k++) begin
      if (en[k]) u_d_r[k] <= u_d_r[k-1];
    end
    for (int k = 7; k <= 12; k++) begin
      if (en[k]) v_d_r[k] <= v_d_r[k-1];
    end
  end

  // stages 11..15: blend along x, then z, then scale to Q16
  assign d0 = 25'(corner_w[1]) - 25'(corner_w[0]);
  assign d1 = 25'(corner_w[3]) - 25'(corner_w[2]);
  assign d2 = 25'(nx1_r) - 25'(nx0_r);

  always_ff @(posedge clk) begin
    if (en[11]) begin
      lp0_r <= PW'(d0) * PW'($signed({1'b0, u_d_r[10]}));
      lp1_r <= PW'(d1) * PW'($signed({1'b0, u_d_r[10]}));
      n00_r <= corner_w[0];
      n01_r <= corner_w[2];
    end
    if (en[12]) begin
      nx0_r <= 24'(25'(n00_r) + 25'((lp0_r + LHALF) >>> F));
      nx1_r <= 24'(25'(n01_r) + 25'((lp1_r + LHALF) >>> F));
    end
    if (en[13]) begin
      lp2_r  <= PW'(d2) * PW'($signed({1'b0, v_d_r[12]}));
      nx0d_r <= nx0_r;
    end
    if (en[14]) begin
      r_r <= 24'(25'(nx0d_r) + 25'((lp2_r + LHALF) >>> F));
    end
    if (en[15]) begin
      o_r <= NOISE_W'((25'(r_r) + 25'sd64) >>> 7);
    end
  end

  `VN2_ASSERT_NOW(a_stall_full, !in_tready, &v_r, "input stalled while a stage is empty")
  `VN2_ASSERT_NOW(a_out_free, !v_r[NSTG], in_tready, "input stalled with output empty")
  `VN2_ASSERT_NEXT(a_take, in_tvalid && in_tready, v_r[1], "accepted word not in stage 1")
  `VN2_ASSERT_NOW(a_w_range, v_r[5], (u_w <= W_ONE) && (v_w <= W_ONE), "weight above one")
  `VN2_ASSERT_NOW(a_out_range, out_tvalid, (o_r >= -18'sd65536) && (o_r <= 18'sd65536), "sample out of range")

endmodule

`default_nettype wire

@@ rtl/vn2_mul64.sv @@
// Two-stage 64x64 multiplier keeping the low 64 bits of the product.
// Depends on vn2_pkg.
`default_nettype none

module vn2_mul64 (
  input  wire logic            clk,
  input  wire logic [1:0]      en,
  input  wire vn2_pkg::word64_t a,
  input  wire vn2_pkg::word64_t b,
  output vn2_pkg::word64_t     p
);
  import vn2_pkg::*;

  logic [63:0] pp_ll_r;
  logic [31:0] pp_hl_r;
  logic [31:0] pp_lh_r;
  word64_t     p_r;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      pp_ll_r <= 64'(a[31:0]) * 64'(b[31:0]);
      pp_hl_r <= a[63:32] * b[31:0];
      pp_lh_r <= a[31:0] * b[63:32];
    end
    if (en[1]) begin
      p_r <= pp_ll_r + {pp_hl_r + pp_lh_r, 32'h0};
    end
  end

  assign p = p_r;

endmodule

`default_nettype wire

@@ rtl/vn2_weight.sv @@
// Smoothstep weight pipeline, four stages: w = round(round(f*f)*(3-2f)).
// Depends on vn2_pkg.
`default_nettype none

module vn2_weight #(
  parameter int FRAC_BITS = vn2_pkg::FRAC_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic [3:0]           en,
  input  wire logic [FRAC_BITS-1:0] frac,
  output logic [FRAC_BITS:0]        w
);
  import vn2_pkg::*;

  localparam int F = FRAC_BITS;
  localparam logic [2*F:0]   HALF_SQ = (2*F+1)'(1) << (F-1);
  localparam logic [2*F+2:0] HALF_W  = (2*F+3)'(1) << (F-1);
  localparam logic [F+1:0]   THREE   = (F+2)'(3) << F;

  logic [2*F-1:0] sqp_r;
  logic [F+1:0]   k2_r;
  logic [F:0]     sq_r;
  logic [F+1:0]   k3_r;
  logic [2*F+2:0] wp_r;
  logic [F:0]     w_r;
  logic [2*F:0]   sq_sum;
  logic [2*F+2:0] w_sum;

  assign sq_sum = (2*F+1)'(sqp_r) + HALF_SQ;
  assign w_sum  = wp_r + HALF_W;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      sqp_r <= (2*F)'(frac) * (2*F)'(frac);
      k2_r  <= THREE - {1'b0, frac, 1'b0};
    end
    if (en[1]) begin
      sq_r <= sq_sum[2*F:F];
      k3_r <= k2_r;
    end
    if (en[2]) begin
      wp_r <= (2*F+3)'(sq_r) * (2*F+3)'(k3_r);
    end
    if (en[3]) begin
      w_r <= w_sum[2*F:F];
    end
  end

  assign w = w_r;

endmodule

`default_nettype wire

@@ rtl/vn2_mix.sv @@
// Splitmix64 finalizer over five stages, returning the corner value in Q23.
// Depends on vn2_pkg and vn2_mul64.
`default_nettype none

module vn2_mix (
  input  wire logic             clk,
  input  wire logic [4:0]       en,
  input  wire vn2_pkg::word64_t key,
  output vn2_pkg::corner_t      corner
);
  import vn2_pkg::*;

  word64_t x1;
  word64_t m1;
  word64_t x2;
  word64_t m2;
  word64_t fin;
  corner_t corner_r;

  assign x1 = key ^ (key >> 30);

  vn2_mul64 u_mul1 (
    .clk (clk),
    .en  (en[1:0]),
    .a   (x1),
    .b   (MIX_C1),
    .p   (m1)
  );

  assign x2 = m1 ^ (m1 >> 27);

  vn2_mul64 u_mul2 (
    .clk (clk),
    .en  (en[3:2]),
    .a   (x2),
    .b   (MIX_C2),
    .p   (m2)
  );

  assign fin = m2 ^ (m2 >> 31);

  // top 24 bits minus 2^23: flip the sign bit
  always_ff @(posedge clk) begin
    if (en[4]) begin
      corner_r <= {~fin[63], fin[62:40]};
    end
  end

  assign corner = corner_r;

endmodule

`default_nettype wire
